// ===== rtl/slu_pkg.sv =====
// ---------------------------------------------------------------------------
// String literal unescaper package
// Transaction types, decoder phase codes and character constants shared by
// the core and its checker.
// ---------------------------------------------------------------------------
package slu_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       closing_byte;
    } t_slu_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       error_here;
        logic       end_of_literal;
        logic       literal_ok;
    } t_slu_out;

    localparam logic [2:0] PH_OPEN    = 3'd0;
    localparam logic [2:0] PH_BODY    = 3'd1;
    localparam logic [2:0] PH_ESC     = 3'd2;
    localparam logic [2:0] PH_HEX1    = 3'd3;
    localparam logic [2:0] PH_HEX2    = 3'd4;
    localparam logic [2:0] PH_DISCARD = 3'd5;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;

    // Returns {digit_ok, value}.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] res;
        res = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            res = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            res = {1'b1, 4'(b[2:0] + 3'd1) + 4'd8};
        end
        return res;
    endfunction

endpackage

// ===== rtl/string_literal_unescaper_core.sv =====
// ---------------------------------------------------------------------------
// String literal unescaper core
// Decodes the escapes of a quoted string literal, one raw byte per
// transaction, and gives one result transaction for each input transaction.
// ---------------------------------------------------------------------------
// The block takes one byte per clock cycle unless o_ready is low, returning
// its result in the next cycle; the only storage is the decoder phase, the
// pending high hex digit and a single result register, so the input stays
// ready whenever that register is empty or is being emptied in the same cycle.
module string_literal_unescaper_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  slu_pkg::t_slu_in  i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output slu_pkg::t_slu_out o_data
);
    import slu_pkg::*;

    logic [2:0] r_phase;
    logic [2:0] n_phase;
    logic [3:0] r_nibble;
    logic [3:0] n_nibble;
    logic       r_out_valid;
    t_slu_out   r_out_data;
    t_slu_out   n_out_data;
    logic [4:0] hex;
    logic       accept;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign hex     = hex_digit(i_data.in_byte);

    always_comb begin
        n_phase    = r_phase;
        n_nibble   = r_nibble;
        n_out_data = '0;
        if (i_data.closing_byte) begin
            n_out_data.end_of_literal = 1'b1;
            n_phase = PH_OPEN;
            unique case (r_phase) inside
                PH_ESC, PH_HEX1, PH_HEX2: begin
                    n_out_data.error_here = 1'b1;
                end
                PH_DISCARD: begin
                    n_out_data.literal_ok = 1'b0;
                end
                default: begin
                    n_out_data.literal_ok = 1'b1;
                end
            endcase
        end else begin
            unique case (r_phase)
                PH_BODY: begin
                    if (i_data.in_byte == CH_BACKSLASH) begin
                        n_phase = PH_ESC;
                    end else begin
                        n_out_data.out_byte   = i_data.in_byte;
                        n_out_data.byte_valid = 1'b1;
                    end
                end
                PH_ESC: begin
                    n_phase = PH_BODY;
                    n_out_data.byte_valid = 1'b1;
                    case (i_data.in_byte) inside
                        CH_BACKSLASH, CH_SQUOTE, CH_DQUOTE: begin
                            n_out_data.out_byte = i_data.in_byte;
                        end
                        CH_N: begin
                            n_out_data.out_byte = CH_NEWLINE;
                        end
                        CH_R: begin
                            n_out_data.out_byte = CH_CR;
                        end
                        CH_T: begin
                            n_out_data.out_byte = CH_TAB;
                        end
                        CH_X: begin
                            n_out_data.byte_valid = 1'b0;
                            n_phase = PH_HEX1;
                        end
                        default: begin
                            n_out_data.byte_valid = 1'b0;
                            n_out_data.error_here = 1'b1;
                            n_phase = PH_DISCARD;
                        end
                    endcase
                end
                PH_HEX1: begin
                    if (hex[4]) begin
                        n_nibble = hex[3:0];
                        n_phase  = PH_HEX2;
                    end else begin
                        n_out_data.error_here = 1'b1;
                        n_phase = PH_DISCARD;
                    end
                end
                PH_HEX2: begin
                    if (hex[4]) begin
                        n_out_data.out_byte   = {r_nibble, hex[3:0]};
                        n_out_data.byte_valid = 1'b1;
                        n_phase = PH_BODY;
                    end else begin
                        n_out_data.error_here = 1'b1;
                        n_phase = PH_DISCARD;
                    end
                end
                PH_DISCARD: begin
                    n_phase = PH_DISCARD;
                end
                default: begin
                    n_phase = PH_BODY;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_OPEN;
            r_nibble    <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase     <= n_phase;
                r_nibble    <= n_nibble;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

// ===== rtl/slu_checker.sv =====
// ---------------------------------------------------------------------------
// String literal unescaper checker
// Port-level assertions on the result channel of the core, attached by bind.
// ---------------------------------------------------------------------------
module slu_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_ready,
    input slu_pkg::t_slu_out o_data
);
    import slu_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result transaction changed while stalled");

    a_byte_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.byte_valid |-> !o_data.error_here && !o_data.end_of_literal)
        else $error("decoded byte together with error or end flag");

    a_ok_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.literal_ok |-> o_data.end_of_literal && !o_data.error_here)
        else $error("literal_ok outside a clean end transaction");

    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.byte_valid |-> o_data.out_byte == 8'd0)
        else $error("out_byte nonzero without byte_valid");

endmodule

bind string_literal_unescaper_core slu_checker u_slu_checker (.*);
